// ----- hw/rtl/ncd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared types and constants for the nearest car dispatcher.
// ----------------------------------------------------------------------------
package ncd_pkg;

    localparam int MAX_CARS    = 8;
    localparam int CAR_IDX_W   = $clog2(MAX_CARS);
    localparam int CAR_ID_W    = 4;
    localparam int FLOOR_BITS  = 6;
    localparam int LOAD_W      = 4;
    localparam int AGE_W       = 8;
    localparam int CMD_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

    localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FAULT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WARNING = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_CARS_IN_USE = 2'd0;
    localparam logic [1:0] REG_LOAD_LIMIT  = 2'd1;
    localparam logic [1:0] REG_WARN_HOLD   = 2'd2;

    localparam logic [3:0] RST_CARS_IN_USE = 4'd8;
    localparam logic [3:0] RST_LOAD_LIMIT  = 4'd4;
    localparam logic [7:0] RST_WARN_HOLD   = 8'd5;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_REACHED = 3'd1,
        ST_MOVING  = 3'd2,
        ST_FAULT   = 3'd3,
        ST_WARNING = 3'd4
    } car_state_t;

    typedef enum logic [2:0] {
        OP_STATUS  = 3'd0,
        OP_FAULT   = 3'd1,
        OP_WARN    = 3'd2,
        OP_REQUEST = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCAN  = 2'd1,
        BK_GRANT = 2'd2
    } back_state_t;

    typedef struct packed {
        op_t                   op;
        logic [CAR_IDX_W-1:0]  car;
        logic [FLOOR_BITS-1:0] floor;
        logic [FLOOR_BITS-1:0] target;
    } op_entry_t;

    typedef struct packed {
        logic [3:0] cars_in_use;
        logic [3:0] load_limit;
        logic [7:0] warn_hold;
    } cfg_t;

endpackage : ncd_pkg
`default_nettype wire

// ----- hw/rtl/ncd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncd_front
// Accepts event beats, drops unknown commands and status, fault and warning
// beats with bad car ids, and queues decoded operations for the back end.
// ----------------------------------------------------------------------------
module ncd_front
    import ncd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [15:0]     s_axis_tdata,   // car_id[3:0], floor[9:4], target_floor[15:10]
    input  wire logic [CMD_W-1:0] s_axis_tuser,  // cmd[2:0]
    output logic                 q_valid,
    output op_entry_t            q_entry,
    input  wire logic            q_pop
);

    op_entry_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;

    logic [CAR_ID_W-1:0]   car_id;
    logic [CAR_ID_W-1:0]   car_id_m1;
    logic                  id_ok;
    logic                  keep;
    logic                  push;
    op_entry_t             dec;

    assign car_id    = s_axis_tdata[3:0];
    assign car_id_m1 = car_id - 4'd1;
    assign id_ok     = car_id inside {[1:MAX_CARS]};

    always_comb
    begin
        dec.car    = car_id_m1[CAR_IDX_W-1:0];
        dec.floor  = s_axis_tdata[9:4];
        dec.target = s_axis_tdata[15:10];
        dec.op     = OP_TICK;
        keep       = 1'b0;
        case (s_axis_tuser)
            CMD_STATUS:
            begin
                dec.op = OP_STATUS;
                keep   = id_ok;
            end
            CMD_FAULT:
            begin
                dec.op = OP_FAULT;
                keep   = id_ok;
            end
            CMD_WARNING:
            begin
                dec.op = OP_WARN;
                keep   = id_ok;
            end
            CMD_REQUEST:
            begin
                dec.op = OP_REQUEST;
                keep   = 1'b1;
            end
            CMD_TICK:
            begin
                dec.op = OP_TICK;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (count_reg != '0);
    assign q_entry       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= dec;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule : ncd_front
`default_nettype wire

// ----- hw/rtl/ncd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncd_back
// Holds per-car state, applies events and scans cars one per cycle to
// grant requests. Results leave through an output register.
// ----------------------------------------------------------------------------
module ncd_back
    import ncd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    input  wire op_entry_t   q_entry,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // chosen_car[3:0], move_floor[9:4], zero[15:10]
    output logic             m_axis_tuser    // car_found
);

    back_state_t           state_reg, state_next;

    logic [FLOOR_BITS-1:0] car_floor_reg [MAX_CARS];
    logic [LOAD_W-1:0]     car_load_reg  [MAX_CARS];
    car_state_t            car_status_reg[MAX_CARS];
    logic                  warn_seen_reg [MAX_CARS];
    logic [AGE_W-1:0]      warn_age_reg  [MAX_CARS];

    logic [CAR_IDX_W-1:0]  scan_idx_reg;
    logic [CAR_IDX_W-1:0]  best_idx_reg;
    logic                  best_found_reg;
    logic [FLOOR_BITS-1:0] best_dist_reg;
    logic [FLOOR_BITS-1:0] req_floor_reg;
    logic [FLOOR_BITS-1:0] req_target_reg;

    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [CAR_ID_W-1:0]   out_car_reg;
    logic [FLOOR_BITS-1:0] out_floor_reg;

    logic                  do_event;
    logic                  do_start;
    logic                  do_scan;
    logic                  do_grant;
    logic                  out_free;

    logic [CAR_IDX_W-1:0]  rd_idx;
    logic [FLOOR_BITS-1:0] rd_floor;
    logic [LOAD_W-1:0]     rd_load;
    car_state_t            rd_status;
    logic                  rd_seen;
    logic [AGE_W-1:0]      rd_age;
    logic [FLOOR_BITS-1:0] car_dist;
    logic                  cand;
    logic                  take;
    logic                  scan_last;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign scan_last = (scan_idx_reg == CAR_IDX_W'(MAX_CARS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_entry.op == OP_REQUEST)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = BK_GRANT;
                end
            end
            BK_GRANT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        do_event = 1'b0;
        do_start = 1'b0;
        do_scan  = 1'b0;
        do_grant = 1'b0;
        rd_idx   = q_entry.car;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                do_event = q_valid && (q_entry.op != OP_REQUEST);
                do_start = q_valid && (q_entry.op == OP_REQUEST);
            end
            BK_SCAN:
            begin
                do_scan = 1'b1;
                rd_idx  = scan_idx_reg;
            end
            BK_GRANT:
            begin
                do_grant = out_free;
                rd_idx   = best_idx_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign rd_floor  = car_floor_reg[rd_idx];
    assign rd_load   = car_load_reg[rd_idx];
    assign rd_status = car_status_reg[rd_idx];
    assign rd_seen   = warn_seen_reg[rd_idx];
    assign rd_age    = warn_age_reg[rd_idx];

    assign car_dist = (rd_floor > req_floor_reg) ? (rd_floor - req_floor_reg)
                                                 : (req_floor_reg - rd_floor);
    assign cand = ((rd_status == ST_IDLE) || (rd_status == ST_REACHED))
                  && (rd_load < cfg.load_limit)
                  && ({1'b0, scan_idx_reg} < cfg.cars_in_use);
    assign take = cand && (!best_found_reg || car_dist < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            out_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            scan_idx_reg   <= '0;
            for (int i = 0; i < MAX_CARS; i++)
            begin
                car_floor_reg[i]  <= '0;
                car_load_reg[i]   <= '0;
                car_status_reg[i] <= ST_IDLE;
                warn_seen_reg[i]  <= 1'b0;
                warn_age_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (do_grant)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (do_start)
            begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            else if (do_scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (take)
                begin
                    best_found_reg <= 1'b1;
                end
            end

            if (do_event)
            begin
                case (q_entry.op)
                    OP_STATUS:
                    begin
                        car_floor_reg[rd_idx] <= q_entry.floor;
                        if (rd_load != '0)
                        begin
                            car_load_reg[rd_idx] <= rd_load - 1'b1;
                        end
                        if (!rd_seen || rd_age > cfg.warn_hold)
                        begin
                            car_status_reg[rd_idx] <= ST_REACHED;
                        end
                    end
                    OP_FAULT:
                    begin
                        car_status_reg[rd_idx] <= ST_FAULT;
                    end
                    OP_WARN:
                    begin
                        car_status_reg[rd_idx] <= ST_WARNING;
                        warn_seen_reg[rd_idx]  <= 1'b1;
                        warn_age_reg[rd_idx]   <= '0;
                    end
                    OP_TICK:
                    begin
                        for (int i = 0; i < MAX_CARS; i++)
                        begin
                            if (warn_seen_reg[i] && warn_age_reg[i] != AGE_MAX)
                            begin
                                warn_age_reg[i] <= warn_age_reg[i] + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (do_grant && best_found_reg)
            begin
                car_status_reg[rd_idx] <= ST_MOVING;
                if (rd_load != LOAD_MAX)
                begin
                    car_load_reg[rd_idx] <= rd_load + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_start)
        begin
            req_floor_reg  <= q_entry.floor;
            req_target_reg <= q_entry.target;
        end
        if (do_scan && take)
        begin
            best_idx_reg  <= scan_idx_reg;
            best_dist_reg <= car_dist;
        end
        if (do_grant)
        begin
            out_found_reg <= best_found_reg;
            out_car_reg   <= best_found_reg ? (CAR_ID_W'(best_idx_reg) + 4'd1) : '0;
            out_floor_reg <= best_found_reg ? req_target_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {6'd0, out_floor_reg, out_car_reg};

`ifndef NO_ASSERTIONS
    a_found_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_car_reg != '0))
        else $error("grant without a car id");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("no-car result carries data");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        do_start |=> (state_reg == BK_SCAN && scan_idx_reg == '0 && !best_found_reg))
        else $error("scan did not start clean");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !q_pop)
        else $error("queue popped while busy");
`endif

endmodule : ncd_back
`default_nettype wire

// ----- hw/rtl/nearest_car_dispatcher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_car_dispatcher_core
// Tracks car floor, load and status; assigns each request to the nearest
// free car below the load limit.
// ----------------------------------------------------------------------------
// Requests are handled one at a time: a request is popped, the scan checks
//   one car per cycle over all 8 cars, and the grant waits for a free output.
// Other events are applied one per cycle while no request is in progress.
// The 4-entry event queue absorbs beats while a request scans.
// Reset: asynchronous; cars idle at floor 0 with zero load, registers at
//   8 cars, load limit 4, warning hold 5.
// ----------------------------------------------------------------------------
module nearest_car_dispatcher_core
    import ncd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // car_id[3:0], floor[9:4], target_floor[15:10]
    input  wire logic [CMD_W-1:0]      s_axis_tuser,  // cmd[2:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // chosen_car[3:0], move_floor[9:4]
    output logic                       m_axis_tuser,  // car_found
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    cfg_t      cfg_reg;
    logic      cfg_wr;
    logic [1:0] reg_idx;
    logic      q_valid;
    logic      q_pop;
    op_entry_t q_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cars_in_use <= RST_CARS_IN_USE;
            cfg_reg.load_limit  <= RST_LOAD_LIMIT;
            cfg_reg.warn_hold   <= RST_WARN_HOLD;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_CARS_IN_USE: cfg_reg.cars_in_use <= pwdata[3:0];
                REG_LOAD_LIMIT:  cfg_reg.load_limit  <= pwdata[3:0];
                REG_WARN_HOLD:   cfg_reg.warn_hold   <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CARS_IN_USE: prdata = {28'd0, cfg_reg.cars_in_use};
            REG_LOAD_LIMIT:  prdata = {28'd0, cfg_reg.load_limit};
            REG_WARN_HOLD:   prdata = {24'd0, cfg_reg.warn_hold};
            default:         prdata = '0;
        endcase
    end

    ncd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop)
    );

    ncd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule : nearest_car_dispatcher_core
`default_nettype wire
